### rtl/ddct_pkg.sv
`timescale 1ns / 1ps

package ddct_pkg;

  localparam int unsigned TimeWidth    = 32;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = TimeWidth;
  localparam int unsigned DivCntWidth  = $clog2(TimeWidth);
  localparam int unsigned StatusWidth  = 2;

  localparam logic [DivCntWidth-1:0] DivLastCnt = DivCntWidth'(TimeWidth - 1);

  // operation codes
  localparam logic OpStart  = 1'b0;
  localparam logic OpSample = 1'b1;

  // timer modes
  localparam logic [1:0] ModeRepeat  = 2'd0;
  localparam logic [1:0] ModeOneshot = 2'd1;

  // status codes
  localparam logic [StatusWidth-1:0] StatusActive = 2'd0;
  localparam logic [StatusWidth-1:0] StatusOn     = 2'd1;
  localparam logic [StatusWidth-1:0] StatusOff    = 2'd2;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] CfgLeadIn  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgOnTime  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgOffTime = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CfgMode    = 2'd3;

  typedef logic [TimeWidth-1:0] time_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic skip_div;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/ddct_in_if.sv
`timescale 1ns / 1ps

interface ddct_in_if
  import ddct_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  operation;
  time_t current_time;

  modport source (output valid, output operation, output current_time, input ready);
  modport sink (input valid, input operation, input current_time, output ready);
endinterface

### rtl/ddct_out_if.sv
`timescale 1ns / 1ps

interface ddct_out_if
  import ddct_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [StatusWidth-1:0] status;
  logic                   tick_pulse;

  modport source (output valid, output status, output tick_pulse, input ready);
  modport sink (input valid, input status, input tick_pulse, output ready);
endinterface

### rtl/ddct_ctrl.sv
`timescale 1ns / 1ps

module ddct_ctrl
  import ddct_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [1:0] IdleS = 2'd0;
  localparam logic [1:0] PrepS = 2'd1;
  localparam logic [1:0] DivS  = 2'd2;
  localparam logic [1:0] FinS  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [DivCntWidth-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      IdleS: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = PrepS;
        end
      end
      PrepS: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = stat_i.skip_div ? FinS : DivS;
      end
      DivS: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == DivLastCnt) begin
          state_d = FinS;
        end
      end
      FinS: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = IdleS;
        end
      end
      default: begin
        state_d = IdleS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IdleS;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### rtl/ddct_dp.sv
`timescale 1ns / 1ps

module ddct_dp
  import ddct_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                    operation_i,
  input  time_t                   current_time_i,
  input  dp_cmd_t                 cmd_i,
  output dp_stat_t                stat_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [StatusWidth-1:0]  status_o,
  output logic                    tick_pulse_o
);

  time_t      lead_q, on_q, off_q;
  logic [1:0] mode_q;

  time_t start_q;
  logic  phase_q, phase_d;

  logic  op_q;
  time_t el_q;
  time_t per_q;
  time_t dvd_q;
  time_t rem_q;
  logic  past_lead_q;

  logic                   out_valid_q;
  logic [StatusWidth-1:0] status_q, status_d;
  logic                   tick_q, tick_d;

  logic [TimeWidth:0]   trial;
  logic [TimeWidth+1:0] diff;
  logic                 over_per;
  logic                 rem_on;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      on_q   <= '0;
      off_q  <= '0;
      mode_q <= ModeRepeat;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLeadIn:  lead_q <= cfg_wdata_i[TimeWidth-1:0];
        CfgOnTime:  on_q   <= cfg_wdata_i[TimeWidth-1:0];
        CfgOffTime: off_q  <= cfg_wdata_i[TimeWidth-1:0];
        CfgMode:    mode_q <= cfg_wdata_i[1:0];
        default: begin
        end
      endcase
    end
  end

  assign stat_o.skip_div = (op_q == OpStart) || !(el_q > lead_q) ||
                           ((on_q + off_q) == '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // one restoring step of the remainder
  assign trial = {rem_q, dvd_q[TimeWidth-1]};
  assign diff  = {1'b0, trial} - {2'b00, per_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= operation_i;
      el_q <= current_time_i - start_q;
    end else if (cmd_i.prep) begin
      el_q        <= el_q - lead_q;
      dvd_q       <= el_q - lead_q;
      per_q       <= on_q + off_q;
      past_lead_q <= el_q > lead_q;
      rem_q       <= '0;
    end else if (cmd_i.step) begin
      dvd_q <= {dvd_q[TimeWidth-2:0], 1'b0};
      rem_q <= diff[TimeWidth+1] ? trial[TimeWidth-1:0] : diff[TimeWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else if (cmd_i.load && (operation_i == OpStart)) begin
      start_q <= current_time_i;
    end
  end

  assign over_per = (el_q > per_q) && (mode_q != ModeRepeat);
  assign rem_on   = rem_q < on_q;

  // result and phase edge decision
  always_comb begin
    status_d = StatusActive;
    tick_d   = 1'b0;
    phase_d  = phase_q;
    if ((op_q == OpSample) && past_lead_q) begin
      if (over_per) begin
        if (mode_q == ModeOneshot) begin
          tick_d   = 1'b1;
          status_d = StatusOn;
        end else begin
          tick_d   = phase_q;
          status_d = StatusOff;
        end
      end else if (rem_on) begin
        if (!phase_q) begin
          tick_d   = 1'b1;
          phase_d  = 1'b1;
          status_d = (mode_q == ModeOneshot) ? StatusOn : StatusActive;
        end
      end else if (phase_q) begin
        tick_d   = 1'b1;
        phase_d  = 1'b0;
        status_d = (mode_q == ModeRepeat) ? StatusActive : StatusOff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      phase_q     <= phase_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= status_d;
      tick_q   <= tick_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign tick_pulse_o = tick_q;

endmodule

### rtl/delayed_duty_cycle_timer.sv
`timescale 1ns / 1ps
// start requests and samples inside the lead-in or with a zero period skip the remainder
//   loop; other samples run the 32-step remainder loop between prep and finish
// one request is taken at a time; the remainder unit makes one bit per cycle
// a finished result waits in the output register while the next request is taken
// reset (rst_ni low, asynchronous): registers, start time and phase cleared, output empty

module delayed_duty_cycle_timer
  import ddct_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  ddct_in_if.sink                 in_req,
  ddct_out_if.source              out_rsp
);

  // command and status link between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: idle -> prep -> remainder steps (only when needed) -> finish
  ddct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_req.valid),
    .in_ready_o (in_req.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: config registers, elapsed time, remainder unit, phase and output register
  ddct_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (in_req.operation),
    .current_time_i (in_req.current_time),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (out_rsp.ready),
    .out_valid_o    (out_rsp.valid),
    .status_o       (out_rsp.status),
    .tick_pulse_o   (out_rsp.tick_pulse)
  );

endmodule

### rtl/ddct_checker.sv
`timescale 1ns / 1ps

module ddct_checker
  import ddct_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   in_op_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [StatusWidth-1:0] status_i,
  input logic                   tick_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> !in_ready_i)
    else $error("request taken while busy");

  // a start request with an empty output gives a quiet result after prep and finish
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_op_i == OpStart) && !out_valid_i) |->
      ##3 (out_valid_i && (status_i == StatusActive) && !tick_i))
    else $error("start request result wrong or late");

  // just-turned-on status always comes with a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (status_i == StatusOn)) |-> tick_i)
    else $error("on status without tick");

  // pending result is held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(status_i) && $stable(tick_i)))
    else $error("result dropped or changed while stalled");

endmodule

bind delayed_duty_cycle_timer ddct_checker u_ddct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_req.valid),
  .in_ready_i  (in_req.ready),
  .in_op_i     (in_req.operation),
  .out_valid_i (out_rsp.valid),
  .out_ready_i (out_rsp.ready),
  .status_i    (out_rsp.status),
  .tick_i      (out_rsp.tick_pulse)
);

### tb/delayed_duty_cycle_timer_tb.sv
`timescale 1ns / 1ps

module delayed_duty_cycle_timer_tb;
  import ddct_pkg::*;

  // clock, limits
  localparam int unsigned ClkPeriod  = 8;
  localparam int unsigned ResetCycles = 11;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 570;
  localparam int unsigned SettleCycles = 40;

  // mode codes the package leaves unnamed
  localparam logic [1:0] ModeSinglePeriod = 2'd2;
  localparam logic [1:0] ModeSpare        = 2'd3;

  // one result as the block reports it
  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic                   tick;
  } timer_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_idx_i;
  logic [CfgDataWidth-1:0] cfg_wdata_i;

  ddct_in_if  in_req ();
  ddct_out_if out_rsp ();

  delayed_duty_cycle_timer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req      (in_req),
    .out_rsp     (out_rsp)
  );

  // predictor copy of the registers and the timer state
  time_t       cfg_lead_in;
  time_t       cfg_on;
  time_t       cfg_off;
  logic [1:0]  cfg_mode;
  time_t       tmr_start;
  logic        tmr_phase_on;

  // results still owed by the block, oldest first
  timer_result_t pending_timer_results[$];

  // bookkeeping
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned start_count;
  int unsigned sample_count;
  int unsigned setting_count;
  int unsigned tick_count;
  int unsigned on_count;
  int unsigned off_count;

  // shared knobs: no idling on either side, and a long receiver hold-off
  bit          steady;
  int unsigned sink_hold;

  always begin
    clk_i = 1'b0;
    #(ClkPeriod / 2);
    clk_i = 1'b1;
    #(ClkPeriod / 2);
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_timer_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // timer behavior: updates the predictor state and returns the expected result
  function automatic timer_result_t predict_timer(input logic op, input time_t now);
    timer_result_t res;
    time_t         elapsed;
    time_t         period;
    time_t         remainder;
    logic          settled;
    res.status = StatusActive;
    res.tick   = 1'b0;
    settled    = 1'b0;
    if (op == OpStart) begin
      tmr_start = now;
    end else begin
      elapsed = now - tmr_start;
      // status stays active until the lead-in is strictly exceeded
      if (elapsed > cfg_lead_in) begin
        elapsed = elapsed - cfg_lead_in;
        period  = cfg_on + cfg_off;
        // past the first period the non-repeating modes report a fixed status
        if (elapsed > period && cfg_mode != ModeRepeat) begin
          settled = 1'b1;
          if (cfg_mode == ModeOneshot) begin
            res.tick   = 1'b1;
            res.status = StatusOn;
          end else begin
            // single period (and the spare code): tick only while still on
            res.tick   = tmr_phase_on;
            res.status = StatusOff;
          end
        end
        if (!settled) begin
          // zero period counts as remainder zero
          remainder = (period != '0) ? elapsed % period : '0;
          if (remainder < cfg_on) begin
            if (!tmr_phase_on) begin
              res.tick     = 1'b1;
              tmr_phase_on = 1'b1;
              res.status   = (cfg_mode == ModeOneshot) ? StatusOn : StatusActive;
            end
          end else if (tmr_phase_on) begin
            res.tick     = 1'b1;
            tmr_phase_on = 1'b0;
            res.status   = (cfg_mode == ModeRepeat) ? StatusActive : StatusOff;
          end
        end
      end
    end
    return res;
  endfunction

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk_i) begin
    timer_result_t want;
    if (rst_ni && out_rsp.valid && out_rsp.ready) begin
      if (pending_timer_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result status %0d tick %0d", $time, out_rsp.status,
                 out_rsp.tick_pulse);
      end else begin
        want = pending_timer_results.pop_front();
        if (out_rsp.status !== want.status) begin
          mismatch_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_rsp.status);
        end
        if (out_rsp.tick_pulse !== want.tick) begin
          mismatch_count++;
          $display("%0t: tick_pulse expected %0d actual %0d", $time, want.tick,
                   out_rsp.tick_pulse);
        end
        tick_count += want.tick;
        if (want.status == StatusOn)  on_count++;
        if (want.status == StatusOff) off_count++;
      end
    end
  end

  // receiver: random stall per result, plus a long hold-off on demand
  initial begin : result_sink
    int unsigned stall;
    out_rsp.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (sink_hold > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (sink_hold) @(posedge clk_i);
        sink_hold = 0;
      end
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_rsp.ready <= 1'b1;
      do @(posedge clk_i); while (!out_rsp.valid);
    end
  end

  // sends one request; valid stays high into the next request unless a gap is drawn
  task automatic send_request(input logic op, input time_t now);
    int unsigned gap;
    in_req.valid        <= 1'b1;
    in_req.operation    <= op;
    in_req.current_time <= now;
    do @(posedge clk_i); while (!in_req.ready);
    pending_timer_results.push_back(predict_timer(op, now));
    if (op == OpStart) start_count++;
    else sample_count++;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // sender pauses until every owed result has come back
  task automatic drain_results();
    in_req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_timer_results.size() != 0) @(posedge clk_i);
  endtask

  // writes all four registers back to back while the block is idle
  task automatic set_timer(input time_t lead, input time_t on, input time_t off,
                           input logic [1:0] mode);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgLeadIn;
    cfg_wdata_i <= lead;
    @(posedge clk_i);
    cfg_idx_i   <= CfgOnTime;
    cfg_wdata_i <= on;
    @(posedge clk_i);
    cfg_idx_i   <= CfgOffTime;
    cfg_wdata_i <= off;
    @(posedge clk_i);
    cfg_idx_i   <= CfgMode;
    cfg_wdata_i <= CfgDataWidth'(mode);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_lead_in = lead;
    cfg_on      = on;
    cfg_off     = off;
    cfg_mode    = mode;
    setting_count++;
  endtask

  // registers at reset: everything zero, repeating mode, zero period
  task automatic test_reset_state();
    send_request(OpStart, 32'd0);
    send_request(OpSample, 32'd0);
    send_request(OpSample, 32'd5);
  endtask

  // lead-in boundary, on and off edges, wrap into later periods
  task automatic test_repeat_edges();
    set_timer(32'd3, 32'd4, 32'd2, ModeRepeat);
    send_request(OpStart, 32'd100);
    send_request(OpSample, 32'd103);   // exactly at the lead-in end
    send_request(OpSample, 32'd104);   // first on edge
    send_request(OpSample, 32'd107);   // off edge
    send_request(OpSample, 32'd113);   // later period, already off
    send_request(OpSample, 32'd109);   // back on at a period start
  endtask

  // one-shot: start near the top of the clock so elapsed wraps
  task automatic test_oneshot();
    set_timer(32'd0, 32'd5, 32'd5, ModeOneshot);
    send_request(OpStart, 32'hFFFF_FFFE);
    send_request(OpSample, 32'd1);
    send_request(OpSample, 32'd7);
    send_request(OpSample, 32'd20);    // past the period
  endtask

  // single period: tick past the period only while the phase is on
  task automatic test_single_period();
    set_timer(32'd2, 32'd3, 32'd3, ModeSinglePeriod);
    send_request(OpStart, 32'd50);
    send_request(OpSample, 32'd53);
    send_request(OpSample, 32'd60);
    send_request(OpSample, 32'd61);
    send_request(OpSample, 32'd56);
    send_request(OpSample, 32'd70);
  endtask

  // zero period with the spare mode code, then the widest values
  task automatic test_extremes();
    set_timer(32'd0, 32'd0, 32'd0, ModeSpare);
    send_request(OpStart, 32'd0);
    send_request(OpSample, 32'hFFFF_FFFF);
    set_timer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ModeRepeat);
    send_request(OpSample, 32'hFFFF_FFFE);
    // on plus off wraps to a period of one
    set_timer(32'd1, 32'hFFFF_FFFF, 32'd2, ModeOneshot);
    send_request(OpSample, 32'd10);
    send_request(OpSample, 32'd2);
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    set_timer(32'd2, 32'd6, 32'd4, ModeRepeat);
    steady    = 1'b1;
    sink_hold = 200;
    send_request(OpStart, $urandom);
    repeat (15) send_request(OpSample, $urandom_range(0, 40) + tmr_start);
    steady = 1'b0;
    drain_results();
  endtask

  function automatic time_t pick_duration();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  // start followed by samples spread over the lead-in and a few periods
  task automatic test_random_phases(input int unsigned n_items);
    int unsigned sent;
    int unsigned in_phase;
    int unsigned phase_idx;
    int unsigned n_samples;
    longint      reach;
    time_t       base;
    sent      = 0;
    phase_idx = 0;
    while (sent < n_items) begin
      set_timer(pick_duration(), pick_duration(), pick_duration(), 2'($urandom_range(0, 3)));
      steady   = (phase_idx % 4 == 3);
      in_phase = 0;
      reach = longint'(cfg_lead_in) + 3 * longint'(time_t'(cfg_on + cfg_off)) + 4;
      if (reach > longint'(32'hFFFF_FFFF)) reach = longint'(32'hFFFF_FFFF);
      while (in_phase < 45) begin
        base = $urandom;
        send_request(OpStart, base);
        n_samples = $urandom_range(2, 10);
        in_phase += n_samples + 1;
        repeat (n_samples) begin
          case ($urandom_range(0, 19))
            0:       send_request(OpStart, $urandom);    // stray restart
            1, 2:    send_request(OpSample, $urandom);   // noise sample
            default: send_request(OpSample, base + $urandom_range(0, 32'(reach)));
          endcase
        end
      end
      sent += in_phase;
      phase_idx++;
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CfgLeadIn;
    cfg_wdata_i         <= '0;
    in_req.valid        <= 1'b0;
    in_req.operation    <= OpStart;
    in_req.current_time <= '0;
    // predictor starts from the reset state
    cfg_lead_in  = '0;
    cfg_on       = '0;
    cfg_off      = '0;
    cfg_mode     = ModeRepeat;
    tmr_start    = '0;
    tmr_phase_on = 1'b0;
    steady       = 1'b0;
    sink_hold    = 0;
    cycle_count  = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_repeat_edges();
    test_oneshot();
    test_single_period();
    test_extremes();
    test_output_backpressure();
    test_random_phases(RandomItems);

    // let any stray result show up before judging
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    $display("ran %0d starts and %0d samples over %0d timer settings", start_count,
             sample_count, setting_count);
    $display("saw %0d ticks, %0d turned-on and %0d turned-off results", tick_count,
             on_count, off_count);
    if (mismatch_count == 0 && pending_timer_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### delayed_duty_cycle_timer.f
rtl/ddct_pkg.sv
rtl/ddct_in_if.sv
rtl/ddct_out_if.sv
rtl/ddct_ctrl.sv
rtl/ddct_dp.sv
rtl/delayed_duty_cycle_timer.sv
rtl/ddct_checker.sv
tb/delayed_duty_cycle_timer_tb.sv
